// ----- design/mpvm_pkg.sv -----
// Shared constants and codes for the motor position/velocity model
package mpvm_pkg;

  localparam int OPCODE_W = 2;
  localparam int WORD_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W    = 34;

  // command opcodes
  localparam logic [OPCODE_W-1:0] OP_VELOCITY  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POSITION  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK      = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_TELEMETRY = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MINIMUM  = 2'd2;

  // register reset values
  localparam logic [WORD_W-1:0] STEP_GAIN_RESET = 16'd8236;

  // fixed point constants
  localparam logic signed [WORD_W-1:0] QUARTER_SCALE = 16'sd8191;
  localparam logic signed [ACC_W-1:0]  FULL_SCALE_Q  = 34'sh0_7FFF_0000;
  localparam logic signed [ACC_W-1:0]  ACC_MAX       = 34'sh1_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0]  ACC_MIN       = 34'sh2_0000_0000;

  // direction codes (two's complement)
  localparam logic signed [1:0] DIR_STOPPED  = 2'sb00;
  localparam logic signed [1:0] DIR_FORWARD  = 2'sb01;
  localparam logic signed [1:0] DIR_BACKWARD = 2'sb11;

endpackage

// ----- design/mpvm_in_if.sv -----
// Command input channel: valid/ready with opcode and value
interface mpvm_in_if;
  import mpvm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic signed [WORD_W-1:0] command_value;

  modport source (output valid, output opcode, output command_value, input ready);
  modport sink (input valid, input opcode, input command_value, output ready);
endinterface

// ----- design/mpvm_out_if.sv -----
// Telemetry output channel: valid/ready with position and velocity words
interface mpvm_out_if;
  import mpvm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] position_word;
  logic signed [WORD_W-1:0] velocity_word;

  modport source (output valid, output position_word, output velocity_word, input ready);
  modport sink (input valid, input position_word, input velocity_word, output ready);
endinterface

// ----- design/mpvm_cfg_if.sv -----
// Configuration write channel: valid/ready with register index and data
interface mpvm_cfg_if;
  import mpvm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/motor_position_velocity_model_top.sv -----
// Top level of the motor position/velocity model
//
// Channels: in_item carries decoded commands (opcode, command_value), out_item
// returns telemetry items (position_word, velocity_word), cfg writes the
// position_mode, step_gain and wrap_minimum registers (always ready).
// Velocity, position and tick commands update the internal state and give no
// item back; a telemetry request gives exactly one output item.
// Order: an accepted item is registered in the input stage and processed from
// there; a telemetry item then passes into the output register, which drives out_item.
// Throughput: one item per cycle unless a telemetry item waits for the output
// register; the single tick multiply-add, its saturation and the snap or wrap
// compare sit between the input stage and the state and result registers.
// Stall: the output register holds its item while out_item.ready is low; a
// telemetry item waiting in the input stage holds in_item.ready low until the
// output register frees; other commands keep flowing.
// Reset (synchronous, active high): position, velocity, target and direction
// go to zero, registers to their reset values, both stages empty.
module motor_position_velocity_model_top (
  input logic         clk,
  input logic         rst,
  mpvm_in_if.sink     in_item,
  mpvm_out_if.source  out_item,
  mpvm_cfg_if.sink    cfg
);
  import mpvm_pkg::*;

  // configuration registers
  logic                     position_mode;
  logic [WORD_W-1:0]        step_gain;
  logic signed [WORD_W-1:0] wrap_minimum;

  // model state
  logic signed [ACC_W-1:0]  position_acc;
  logic signed [WORD_W-1:0] velocity_reg;
  logic signed [WORD_W-1:0] target_reg;
  logic signed [1:0]        direction_reg;

  logic signed [ACC_W-1:0]  position_acc_next;
  logic signed [WORD_W-1:0] velocity_reg_next;
  logic signed [WORD_W-1:0] target_reg_next;
  logic signed [1:0]        direction_reg_next;

  // input stage
  logic                     s1_valid;
  logic [OPCODE_W-1:0]      s1_opcode;
  logic signed [WORD_W-1:0] s1_value;

  // output register
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_position;
  logic signed [WORD_W-1:0] out_velocity;

  // handshake
  logic s1_is_tel;
  logic out_free;
  logic s1_go;
  logic in_fire;

  // datapath
  logic signed [32:0]       tick_product;
  logic signed [ACC_W+1:0]  tick_sum;
  logic signed [ACC_W-1:0]  tick_acc;
  logic signed [ACC_W-1:0]  target_q;
  logic signed [ACC_W-1:0]  cmd_q;
  logic signed [ACC_W-1:0]  min_q;
  logic signed [ACC_W+1:0]  wrap_hi_sum;
  logic signed [ACC_W+1:0]  wrap_lo_sum;
  logic                     snap;
  logic signed [17:0]       tel_quot;
  logic signed [WORD_W-1:0] tel_position;

  // saturate a widened accumulator value to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W-1:0] r;
    if ((v[ACC_W+1:ACC_W-1] == 3'b000) || (v[ACC_W+1:ACC_W-1] == 3'b111)) begin
      r = v[ACC_W-1:0];
    end else if (v[ACC_W+1]) begin
      r = ACC_MIN;
    end else begin
      r = ACC_MAX;
    end
    return r;
  endfunction

  // handshake control
  assign s1_is_tel = (s1_opcode == OP_TELEMETRY);
  assign out_free  = !out_valid || out_item.ready;
  assign s1_go     = s1_valid && (!s1_is_tel || out_free);
  assign in_item.ready = !s1_valid || s1_go;
  assign in_fire   = in_item.valid && in_item.ready;
  assign cfg.ready = 1'b1;

  assign out_item.valid         = out_valid;
  assign out_item.position_word = out_position;
  assign out_item.velocity_word = out_velocity;

  // tick: multiply-add with saturation
  assign tick_product = velocity_reg * $signed({1'b0, step_gain});
  assign tick_sum     = {{2{position_acc[ACC_W-1]}}, position_acc}
                      + {{3{tick_product[32]}}, tick_product};
  assign tick_acc     = sat_acc(tick_sum);

  // scaled target, command and wrap minimum
  assign target_q = {{2{target_reg[WORD_W-1]}}, target_reg, 16'h0000};
  assign cmd_q    = {{2{s1_value[WORD_W-1]}}, s1_value, 16'h0000};
  assign min_q    = {{2{wrap_minimum[WORD_W-1]}}, wrap_minimum, 16'h0000};

  // overshoot snap and wrap candidates
  assign snap = ((direction_reg == DIR_FORWARD) && (tick_acc > target_q))
             || (direction_reg[1] && (tick_acc < target_q));
  assign wrap_hi_sum = {{2{tick_acc[ACC_W-1]}}, tick_acc}
                     - {{2{FULL_SCALE_Q[ACC_W-1]}}, FULL_SCALE_Q}
                     + {{2{min_q[ACC_W-1]}}, min_q};
  assign wrap_lo_sum = {{2{tick_acc[ACC_W-1]}}, tick_acc}
                     + {{2{FULL_SCALE_Q[ACC_W-1]}}, FULL_SCALE_Q}
                     - {{2{min_q[ACC_W-1]}}, min_q};

  // telemetry: divide by 2^16 toward zero, saturate to 16 bits
  assign tel_quot = position_acc[ACC_W-1:16]
                  + {17'd0, (position_acc[ACC_W-1] && (|position_acc[15:0]))};
  assign tel_position = ((tel_quot[17:15] == 3'b000) || (tel_quot[17:15] == 3'b111))
                      ? tel_quot[WORD_W-1:0]
                      : (tel_quot[17] ? 16'sh8000 : 16'sh7FFF);

  // next state for the item in the input stage
  always_comb begin
    position_acc_next  = position_acc;
    velocity_reg_next  = velocity_reg;
    target_reg_next    = target_reg;
    direction_reg_next = direction_reg;
    if (s1_go) begin
      unique case (s1_opcode)
        OP_VELOCITY: begin
          velocity_reg_next  = s1_value;
          direction_reg_next = DIR_FORWARD;
        end
        OP_POSITION: begin
          if (position_mode) begin
            target_reg_next = s1_value;
            if (position_acc <= cmd_q) begin
              direction_reg_next = DIR_FORWARD;
              velocity_reg_next  = QUARTER_SCALE;
            end else begin
              direction_reg_next = DIR_BACKWARD;
              velocity_reg_next  = -QUARTER_SCALE;
            end
          end
        end
        OP_TICK: begin
          position_acc_next = tick_acc;
          if (position_mode) begin
            if (snap) begin
              position_acc_next  = target_q;
              velocity_reg_next  = '0;
              direction_reg_next = DIR_STOPPED;
            end
          end else if (tick_acc > FULL_SCALE_Q) begin
            position_acc_next = sat_acc(wrap_hi_sum);
          end else if (tick_acc[ACC_W-1]) begin
            position_acc_next = sat_acc(wrap_lo_sum);
          end
        end
        OP_TELEMETRY: begin
        end
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      position_mode <= 1'b0;
      step_gain     <= STEP_GAIN_RESET;
      wrap_minimum  <= '0;
      position_acc  <= '0;
      velocity_reg  <= '0;
      target_reg    <= '0;
      direction_reg <= DIR_STOPPED;
    end else begin
      if (in_item.ready) begin
        s1_valid <= in_item.valid;
      end
      if (s1_go && s1_is_tel) begin
        out_valid <= 1'b1;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_POSITION_MODE: position_mode <= cfg.data[0];
          CFG_STEP_GAIN:     step_gain     <= cfg.data;
          CFG_WRAP_MINIMUM:  wrap_minimum  <= cfg.data;
          default: begin
          end
        endcase
      end
      position_acc  <= position_acc_next;
      velocity_reg  <= velocity_reg_next;
      target_reg    <= target_reg_next;
      direction_reg <= direction_reg_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode <= in_item.opcode;
      s1_value  <= in_item.command_value;
    end
    if (s1_go && s1_is_tel) begin
      out_position <= tel_position;
      out_velocity <= velocity_reg;
    end
  end

  // a stopped motor has zero velocity
  assert property (@(posedge clk) disable iff (rst)
    (direction_reg == DIR_STOPPED) |-> (velocity_reg == '0))
    else $error("stopped direction with nonzero velocity");

  // a telemetry item leaving the input stage lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_is_tel) |=> out_valid)
    else $error("telemetry item lost");

  // a held input stage keeps its item
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_opcode) && $stable(s1_value)))
    else $error("stalled input stage item changed");

  // the direction code never takes the unused pattern
  assert property (@(posedge clk) disable iff (rst)
    direction_reg != 2'sb10)
    else $error("invalid direction code");

endmodule

// ----- tb/sv/motor_position_velocity_model_top_tb.sv -----
// Self-checking testbench for the motor position/velocity model top level
`timescale 1ns / 100ps

module motor_position_velocity_model_top_tb;
  import mpvm_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] position_word;
    logic signed [WORD_W-1:0] velocity_word;
  } telemetry_t;

  // drive state tracker: mirrors registers and motion state, holds pending telemetry
  class drive_tracker;
    bit                       pos_mode;
    logic [WORD_W-1:0]        gain;
    logic signed [WORD_W-1:0] wrap_min;
    longint                   acc;
    logic signed [WORD_W-1:0] vel;
    logic signed [WORD_W-1:0] target;
    logic signed [1:0]        dir;
    telemetry_t               telemetry_q[$];
    int                       errors;
    int                       checked;
    int                       commands;

    function new();
      pos_mode = 1'b0;
      gain     = STEP_GAIN_RESET;
      wrap_min = '0;
      acc      = 0;
      vel      = '0;
      target   = '0;
      dir      = DIR_STOPPED;
      errors   = 0;
      checked  = 0;
      commands = 0;
    endfunction

    function longint clamp_acc(longint v);
      if (v > longint'(ACC_MAX)) return longint'(ACC_MAX);
      if (v < longint'(ACC_MIN)) return longint'(ACC_MIN);
      return v;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        CFG_POSITION_MODE: pos_mode = data[0];
        CFG_STEP_GAIN:     gain = data;
        CFG_WRAP_MINIMUM:  wrap_min = data;
        default: ;
      endcase
    endfunction

    // update motion state for one accepted item
    function void note_command(logic [OPCODE_W-1:0] op, logic signed [WORD_W-1:0] value);
      longint     tq;
      longint     minq;
      longint     scaled;
      longint     word;
      telemetry_t t;
      commands++;
      case (op)
        OP_VELOCITY: begin
          vel = value;
          dir = DIR_FORWARD;
        end
        OP_POSITION: begin
          if (pos_mode) begin
            target = value;
            scaled = longint'(value) * 65536;
            dir = (acc <= scaled) ? DIR_FORWARD : DIR_BACKWARD;
            vel = (dir == DIR_FORWARD) ? QUARTER_SCALE : -QUARTER_SCALE;
          end
        end
        OP_TICK: begin
          acc = clamp_acc(acc + longint'(vel) * longint'({16'd0, gain}));
          tq = longint'(target) * 65536;
          if (pos_mode) begin
            // snap onto the target once it has been passed
            if ((dir == DIR_FORWARD && acc > tq) || (dir == DIR_BACKWARD && acc < tq)) begin
              acc = tq;
              vel = '0;
              dir = DIR_STOPPED;
            end
          end else begin
            // single wrap between the minimum and full scale
            minq = longint'(wrap_min) * 65536;
            if (acc > longint'(FULL_SCALE_Q))
              acc = clamp_acc(acc - longint'(FULL_SCALE_Q) + minq);
            else if (acc < 0)
              acc = clamp_acc(acc + longint'(FULL_SCALE_Q) - minq);
          end
        end
        default: begin
          word = acc / 65536;
          if (word > 32767) word = 32767;
          if (word < -32768) word = -32768;
          t.position_word = word[15:0];
          t.velocity_word = vel;
          telemetry_q.insert(telemetry_q.size(), t);
        end
      endcase
    endfunction

    function void check_telemetry(logic signed [WORD_W-1:0] pw, logic signed [WORD_W-1:0] vw);
      telemetry_t t;
      if (telemetry_q.size() == 0) begin
        $error("unexpected telemetry item: position_word %0d, velocity_word %0d", pw, vw);
        errors++;
        return;
      end
      t = telemetry_q.pop_front();
      checked++;
      if (pw !== t.position_word) begin
        $error("position_word mismatch: expected %0d, got %0d", t.position_word, pw);
        errors++;
      end
      if (vw !== t.velocity_word) begin
        $error("velocity_word mismatch: expected %0d, got %0d", t.velocity_word, vw);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   src_gaps = 1'b1;
  bit   sink_stalls = 1'b1;
  int   settings_seen = 0;

  drive_tracker tracker = new();

  mpvm_in_if  in_bus();
  mpvm_out_if out_bus();
  mpvm_cfg_if cfg_bus();

  motor_position_velocity_model_top u_top (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_bus),
    .out_item (out_bus),
    .cfg      (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length between items: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!src_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // command payload: extremes, small values near zero, or anything
  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        3: return 16'shFFFF;
        default: return 16'sh0001;
      endcase
    end
    if (r < 50) return 16'(int'($urandom_range(0, 4000)) - 2000);
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_command(logic [OPCODE_W-1:0] op, logic signed [WORD_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.opcode        <= op;
    in_bus.command_value <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.note_command(op, value);
  endtask

  // stop sending and let all telemetry drain, plus the pipeline tail
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (tracker.telemetry_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(bit mode, logic [WORD_W-1:0] gain, logic [WORD_W-1:0] wrap);
    logic [CFG_IDX_W-1:0] idx_list[3];
    logic [WORD_W-1:0]    data_list[3];
    idx_list[0]  = CFG_POSITION_MODE;
    idx_list[1]  = CFG_STEP_GAIN;
    idx_list[2]  = CFG_WRAP_MINIMUM;
    data_list[0] = {15'd0, mode};
    data_list[1] = gain;
    data_list[2] = wrap;
    for (int i = 0; i < 3; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx_list[i];
      cfg_bus.data  <= data_list[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      tracker.write_register(idx_list[i], data_list[i]);
    end
    cfg_bus.valid <= 1'b0;
    settings_seen++;
  endtask

  // receiver backpressure: short and long stalls
  initial begin
    int hold;
    int r;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        hold--;
      end else if (!sink_stalls) begin
        out_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_bus.ready <= 1'b1;
        end else if (r < 95) begin
          out_bus.ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_bus.ready <= 1'b0;
          hold = $urandom_range(10, 50);
        end
      end
    end
  end

  // telemetry monitor
  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready)
      tracker.check_telemetry(out_bus.position_word, out_bus.velocity_word);
  end

  // stimulus
  initial begin
    int                       counted;
    int                       r;
    logic [OPCODE_W-1:0]      op;
    logic signed [WORD_W-1:0] value;
    logic [WORD_W-1:0]        gain_sel;
    logic [WORD_W-1:0]        wrap_sel;
    bit                       mode_sel;

    rst                  <= 1'b1;
    in_bus.valid         <= 1'b0;
    in_bus.opcode        <= OP_VELOCITY;
    in_bus.command_value <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= CFG_POSITION_MODE;
    cfg_bus.data         <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // velocity mode at reset settings: full-scale moves, a wrap below zero,
    // ignored position command, payload of tick and telemetry ignored
    send_command(OP_TELEMETRY, 16'sh7FFF);
    send_command(OP_VELOCITY, 16'sh7FFF);
    send_command(OP_TICK, 16'sh8000);
    send_command(OP_TELEMETRY, 16'sh0000);
    send_command(OP_VELOCITY, 16'sh8000);
    repeat (2) send_command(OP_TICK, 16'sh0000);
    send_command(OP_TELEMETRY, 16'sh8000);
    send_command(OP_POSITION, 16'sd1234);
    send_command(OP_TELEMETRY, 16'sh0000);

    // position mode, largest gain: two backward moves toward targets, forward flag
    // with negative velocity running into accumulator saturation
    wait_drained();
    configure(1'b1, 16'hFFFF, 16'h8001);
    send_command(OP_POSITION, 16'sd100);
    send_command(OP_TICK, 16'sh7FFF);
    send_command(OP_TELEMETRY, 16'sh0000);
    send_command(OP_POSITION, 16'sh8000);
    repeat (5) send_command(OP_TICK, 16'sh0000);
    send_command(OP_TELEMETRY, 16'sh0000);
    send_command(OP_VELOCITY, 16'sh8000);
    repeat (4) send_command(OP_TICK, 16'shFFFF);
    send_command(OP_TELEMETRY, 16'sh0000);

    // random phases over register settings, extremes included
    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      mode_sel = ph[0];
      case (ph)
        2: gain_sel = 16'h0000;
        3: gain_sel = 16'hFFFF;
        7: gain_sel = 16'h0001;
        default: gain_sel = 16'($urandom_range(0, 65535));
      endcase
      case (ph)
        4: wrap_sel = 16'h8001;
        5: wrap_sel = 16'h7FFF;
        8: wrap_sel = 16'h0000;
        default: wrap_sel = 16'(int'($urandom_range(0, 65534)) - 32767);
      endcase
      configure(mode_sel, gain_sel, wrap_sel);
      src_gaps    = (ph % 4 != 1);
      sink_stalls = (ph % 4 != 1);
      counted = 0;
      while (counted < 150) begin
        r = $urandom_range(0, 99);
        if (tracker.pos_mode)
          op = (r < 15) ? OP_VELOCITY : (r < 35) ? OP_POSITION : (r < 75) ? OP_TICK : OP_TELEMETRY;
        else
          op = (r < 20) ? OP_VELOCITY : (r < 25) ? OP_POSITION : (r < 75) ? OP_TICK : OP_TELEMETRY;
        if (op == OP_VELOCITY || op == OP_POSITION)
          value = pick_value();
        else
          value = 16'($urandom_range(0, 65535));
        if (!(op == OP_POSITION && !tracker.pos_mode)) counted++;
        send_command(op, value);
      end
    end

    // drain and let the pipeline settle
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d commands and %0d telemetry items checked", tracker.commands,
             tracker.checked);
    $display("across %0d register settings, gain and wrap extremes in both modes",
             settings_seen);
    if (tracker.errors == 0 && tracker.telemetry_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
